// ===== rtl/cmr_pkg.sv =====
// Shared constants, types and helpers for the cost matrix row and column reduction unit.
package cmr_pkg;

   // Matrix geometry and payload widths.
   localparam int MAX_SIZE   = 8;
   localparam int VALUE_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_SIZE);
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int WORD_BITS  = VALUE_BITS + 1;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;

   // Result total: the field is fixed, the accumulator grows with the parameters.
   localparam int TOTAL_BITS = 19;
   localparam int SUM_BITS   = VALUE_BITS + $clog2(2 * MAX_SIZE);
   localparam int CMP_BITS   = (SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS;

   // Configuration port.
   localparam int SIZE_BITS    = 4;
   localparam int SIZE_RESET   = 8;
   localparam int PADDR_BITS   = 3;
   localparam int PDATA_BITS   = 32;
   localparam int REG_IDX_BITS = 1;
   localparam logic [REG_IDX_BITS-1:0] REG_MATRIX_SIZE = 1'b0;

   // One access to the matrix store: one write port and one read port.
   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
   } mem_req_type;

   // Store address of a matrix entry.
   function automatic logic [ADDR_BITS-1:0] entry_addr(input logic [IDX_BITS-1:0] row,
                                                       input logic [IDX_BITS-1:0] col);
      return {row, col};
   endfunction

endpackage

// ===== rtl/cost_matrix_row_col_reduction_unit.sv =====
// Top level of the cost matrix row and column reduction unit: CSR, loading and store access.
//
//   Channel   Direction  Handshake              Item
//   req_      in         req_valid / req_stall  one matrix entry, row-major
//   rsp_      out        rsp_valid / rsp_stall  one reduced entry, row-major, with the total
//   APB       in         psel / penable         matrix_size register at byte address 0
//
// Loading accepts one item per cycle while req_stall is low.
// Then the row, column and emit passes run in turn, paced by the store's one read port.
// req_stall is high from the last item until the last result enters the output register.
// rsp_stall holds the emit pipeline without losing items. Reset clears the control
// state only; the store contents are undefined until loaded and need no clearing pass.
module cost_matrix_row_col_reduction_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cmr_pkg::VALUE_BITS-1:0]  req_entry_value,
   input  logic                                   req_entry_infinite,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cmr_pkg::VALUE_BITS-1:0]  rsp_reduced_value,
   output logic                                   rsp_reduced_infinite,
   output logic [cmr_pkg::TOTAL_BITS-1:0]         rsp_total_reduction,
   output logic                                   rsp_last_entry,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [cmr_pkg::PADDR_BITS-1:0]         paddr,
   input  logic [cmr_pkg::PDATA_BITS-1:0]         pwdata,
   output logic [cmr_pkg::PDATA_BITS-1:0]         prdata,
   output logic                                   pready
);
   import cmr_pkg::*;

   localparam logic [SIZE_BITS-1:0] SizeMax = SIZE_BITS'(MAX_SIZE);

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [IDX_BITS-1:0]  lr_ff, lr_in, lc_ff, lc_in;
   logic [SIZE_BITS-1:0] size_eff;
   logic [IDX_BITS-1:0]  n_last;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                 csr_write, size_write;
   logic                 req_accept, start, busy;
   mem_req_type          load_req, engine_req, mem_req;
   logic [WORD_BITS-1:0] rd_data;

   // Register decode.
   assign pready     = 1'b1;
   assign reg_idx    = paddr[PADDR_BITS-1 -: REG_IDX_BITS];
   assign csr_write  = psel && penable && pwrite;
   assign size_write = csr_write && (reg_idx == REG_MATRIX_SIZE);
   assign size_in    = size_write ? pwdata[SIZE_BITS-1:0] : size_ff;

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_MATRIX_SIZE) begin
         prdata = {{(PDATA_BITS - SIZE_BITS){1'b0}}, size_ff};
      end
   end

   // Effective size: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_BITS'(1);
      end else if (size_ff > SizeMax) begin
         size_eff = SizeMax;
      end else begin
         size_eff = size_ff;
      end
   end
   assign n_last = IDX_BITS'(size_eff - SIZE_BITS'(1));

   // Load position; a size write restarts loading.
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign start      = req_accept && (lr_ff == n_last) && (lc_ff == n_last);

   always_comb begin
      lr_in = lr_ff;
      lc_in = lc_ff;
      if (size_write) begin
         lr_in = '0;
         lc_in = '0;
      end else if (req_accept) begin
         if (lc_ff == n_last) begin
            lc_in = '0;
            lr_in = (lr_ff == n_last) ? '0 : (lr_ff + 1'b1);
         end else begin
            lc_in = lc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_BITS'(SIZE_RESET);
         lr_ff   <= '0;
         lc_ff   <= '0;
      end else begin
         size_ff <= size_in;
         lr_ff   <= lr_in;
         lc_ff   <= lc_in;
      end
   end

   // Store port: loads while idle, the engine otherwise.
   always_comb begin
      load_req       = '0;
      load_req.we    = req_accept;
      load_req.waddr = entry_addr(lr_ff, lc_ff);
      load_req.wdata = {req_entry_infinite, req_entry_value};
      mem_req        = busy ? engine_req : load_req;
   end

   cmr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cmr_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .n_last               (n_last),
      .rd_data              (rd_data),
      .rsp_stall            (rsp_stall),
      .mem_req              (engine_req),
      .busy                 (busy),
      .rsp_valid            (rsp_valid),
      .rsp_reduced_value    (rsp_reduced_value),
      .rsp_reduced_infinite (rsp_reduced_infinite),
      .rsp_total_reduction  (rsp_total_reduction),
      .rsp_last_entry       (rsp_last_entry)
   );

endmodule

// ===== rtl/cmr_store.sv =====
// Matrix store: a synchronous memory with one write port and one registered read port.
module cmr_store (
   input  logic                           clock,
   input  cmr_pkg::mem_req_type           mem_req,
   output logic [cmr_pkg::WORD_BITS-1:0]  rd_data
);
   import cmr_pkg::*;

   logic [WORD_BITS-1:0] mem_ff [STORE_DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write and read; the read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cmr_engine.sv =====
// Reduction engine: row pass, column pass with write-back, and the emit pipeline.
module cmr_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [cmr_pkg::IDX_BITS-1:0]           n_last,
   input  logic [cmr_pkg::WORD_BITS-1:0]          rd_data,
   input  logic                                   rsp_stall,
   output cmr_pkg::mem_req_type                   mem_req,
   output logic                                   busy,
   output logic                                   rsp_valid,
   output logic signed [cmr_pkg::VALUE_BITS-1:0]  rsp_reduced_value,
   output logic                                   rsp_reduced_infinite,
   output logic [cmr_pkg::TOTAL_BITS-1:0]         rsp_total_reduction,
   output logic                                   rsp_last_entry
);
   import cmr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_SCAN,
      ST_ROW_WAIT,
      ST_COL_SCAN,
      ST_COL_WAIT,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   state_type state_ff, state_in;

   // Read issue counters.
   logic [IDX_BITS-1:0] ra_ff, ra_in, ca_ff, ca_in;

   // Data stage: the entry whose read data is on rd_data.
   logic                d_valid_ff, d_valid_in;
   logic [IDX_BITS-1:0] d_row_ff, d_row_in, d_col_ff, d_col_in;
   logic                d_first_ff, d_first_in, d_last_ff, d_last_in;
   logic                d_colpass_ff, d_colpass_in;

   // Running minimum of the current row or column.
   logic                         m_any_ff, m_any_in;
   logic signed [VALUE_BITS-1:0] m_val_ff, m_val_in;

   // Amounts subtracted from each row and column, and their sum.
   logic signed [VALUE_BITS-1:0] rowsub_ff [MAX_SIZE];
   logic signed [VALUE_BITS-1:0] rowsub_in [MAX_SIZE];
   logic signed [VALUE_BITS-1:0] colsub_ff [MAX_SIZE];
   logic signed [VALUE_BITS-1:0] colsub_in [MAX_SIZE];
   logic [SUM_BITS-1:0]          sum_ff, sum_in;

   // Emit stage: the entry held in the store's read register.
   logic                e_valid_ff, e_valid_in;
   logic [IDX_BITS-1:0] e_col_ff, e_col_in;
   logic                e_last_ff, e_last_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_inf_ff, rsp_inf_in;
   logic [TOTAL_BITS-1:0]        rsp_total_ff, rsp_total_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Helpers.
   logic                         word_inf;
   logic signed [VALUE_BITS-1:0] word_val;
   logic signed [VALUE_BITS-1:0] adj_val;
   logic                         base_any, new_any, take;
   logic signed [VALUE_BITS-1:0] base_m, new_m, line_sub;
   logic                         e_advance;
   logic [TOTAL_BITS-1:0]        total_sat;

   assign word_inf  = rd_data[VALUE_BITS];
   assign word_val  = rd_data[VALUE_BITS-1:0];
   assign e_advance = e_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign total_sat = (CMP_BITS'(sum_ff) > CMP_BITS'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : TOTAL_BITS'(sum_ff);

   // Minimum update for the entry in the data stage.
   always_comb begin
      if (d_colpass_ff && !word_inf) begin
         adj_val = word_val - rowsub_ff[d_row_ff];
      end else begin
         adj_val = word_val;
      end
      base_any = d_first_ff ? 1'b0 : m_any_ff;
      base_m   = m_val_ff;
      take     = !word_inf && (!base_any || (adj_val < base_m));
      new_any  = base_any || !word_inf;
      new_m    = take ? adj_val : base_m;
      line_sub = (new_any && (new_m > 0)) ? new_m : '0;
   end

   // Sequencer, data stage and emit pipeline.
   always_comb begin
      state_in     = state_ff;
      ra_in        = ra_ff;
      ca_in        = ca_ff;
      d_valid_in   = 1'b0;
      d_row_in     = ra_ff;
      d_col_in     = ca_ff;
      d_first_in   = 1'b0;
      d_last_in    = 1'b0;
      d_colpass_in = d_colpass_ff;
      m_any_in     = m_any_ff;
      m_val_in     = m_val_ff;
      rowsub_in    = rowsub_ff;
      colsub_in    = colsub_ff;
      sum_in       = sum_ff;
      e_valid_in   = e_valid_ff && !e_advance;
      e_col_in     = e_col_ff;
      e_last_in    = e_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_inf_in   = rsp_inf_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      mem_req       = '0;
      mem_req.raddr = entry_addr(ra_ff, ca_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ROW_SCAN;
               ra_in    = '0;
               ca_in    = '0;
               sum_in   = '0;
            end
         end
         ST_ROW_SCAN: begin
            // Row-major reads; the row index steps after each row.
            mem_req.re   = 1'b1;
            d_valid_in   = 1'b1;
            d_first_in   = (ca_ff == '0);
            d_last_in    = (ca_ff == n_last);
            d_colpass_in = 1'b0;
            if (ca_ff == n_last) begin
               ca_in = '0;
               if (ra_ff == n_last) begin
                  ra_in    = '0;
                  state_in = ST_ROW_WAIT;
               end else begin
                  ra_in = ra_ff + 1'b1;
               end
            end else begin
               ca_in = ca_ff + 1'b1;
            end
         end
         ST_ROW_WAIT: begin
            state_in = ST_COL_SCAN;
         end
         ST_COL_SCAN: begin
            // Column-major reads; the column index steps after each column.
            mem_req.re   = 1'b1;
            d_valid_in   = 1'b1;
            d_first_in   = (ra_ff == '0);
            d_last_in    = (ra_ff == n_last);
            d_colpass_in = 1'b1;
            if (ra_ff == n_last) begin
               ra_in = '0;
               if (ca_ff == n_last) begin
                  ca_in    = '0;
                  state_in = ST_COL_WAIT;
               end else begin
                  ca_in = ca_ff + 1'b1;
               end
            end else begin
               ra_in = ra_ff + 1'b1;
            end
         end
         ST_COL_WAIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Issue a read whenever the emit stage frees up.
            if (!e_valid_ff || e_advance) begin
               mem_req.re = 1'b1;
               e_valid_in = 1'b1;
               e_col_in   = ca_ff;
               e_last_in  = (ra_ff == n_last) && (ca_ff == n_last);
               if (ca_ff == n_last) begin
                  ca_in = '0;
                  if (ra_ff == n_last) begin
                     ra_in    = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     ra_in = ra_ff + 1'b1;
                  end
               end else begin
                  ca_in = ca_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (e_advance && e_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Data stage: track the line minimum; the column pass writes row-reduced values back.
      if (d_valid_ff) begin
         m_any_in = new_any;
         m_val_in = new_m;
         if (d_colpass_ff) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = entry_addr(d_row_ff, d_col_ff);
            mem_req.wdata = {word_inf, adj_val};
         end
         if (d_last_ff) begin
            if (d_colpass_ff) begin
               colsub_in[d_col_ff] = line_sub;
            end else begin
               rowsub_in[d_row_ff] = line_sub;
            end
            sum_in = sum_ff + {{(SUM_BITS - VALUE_BITS){1'b0}}, line_sub};
         end
      end

      // Output register: load from the emit stage, clear on acceptance.
      if (e_advance) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = word_inf ? '0 : (word_val - colsub_ff[e_col_ff]);
         rsp_inf_in   = word_inf;
         rsp_total_in = total_sat;
         rsp_last_in  = e_last_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ra_ff        <= '0;
         ca_ff        <= '0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ra_ff        <= ra_in;
         ca_ff        <= ca_in;
         d_valid_ff   <= d_valid_in;
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_row_ff     <= d_row_in;
      d_col_ff     <= d_col_in;
      d_first_ff   <= d_first_in;
      d_last_ff    <= d_last_in;
      d_colpass_ff <= d_colpass_in;
      m_any_ff     <= m_any_in;
      m_val_ff     <= m_val_in;
      rowsub_ff    <= rowsub_in;
      colsub_ff    <= colsub_in;
      sum_ff       <= sum_in;
      e_col_ff     <= e_col_in;
      e_last_ff    <= e_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_inf_ff   <= rsp_inf_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_reduced_value    = rsp_value_ff;
   assign rsp_reduced_infinite = rsp_inf_ff;
   assign rsp_total_reduction  = rsp_total_ff;
   assign rsp_last_entry       = rsp_last_ff;

endmodule

// ===== rtl/cmr_checker.sv =====
// Port-level assertions for the reduction unit, bound to the top level.
module cmr_port_checks (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [cmr_pkg::VALUE_BITS-1:0]  rsp_reduced_value,
   input logic                                   rsp_reduced_infinite,
   input logic                                   psel,
   input logic                                   penable,
   input logic                                   pwrite,
   input logic [cmr_pkg::PADDR_BITS-1:0]         paddr,
   input logic [cmr_pkg::PDATA_BITS-1:0]         pwdata,
   input logic [cmr_pkg::PDATA_BITS-1:0]         prdata,
   input logic                                   pready
);
   import cmr_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // An infinite entry always comes out with a zero value.
   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reduced_infinite |-> (rsp_reduced_value == '0))
      else $error("infinite entry with nonzero value");

   // Loading stops only right after an accepted item, the last of a matrix.
   a_stall_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stall rose without an accepted item");

   // A size write reads back on the following cycle.
   a_size_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready &&
      (paddr[PADDR_BITS-1 -: REG_IDX_BITS] == REG_MATRIX_SIZE)
      |=> (paddr[PADDR_BITS-1 -: REG_IDX_BITS] != REG_MATRIX_SIZE) ||
          (prdata[SIZE_BITS-1:0] == $past(pwdata[SIZE_BITS-1:0])))
      else $error("matrix size readback mismatch");

endmodule

bind cost_matrix_row_col_reduction_unit cmr_port_checks u_checker (.*);
